>>> rtl/core/mrd_pkg.sv
package mrd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic [1:0] op;
    } mrd_in_t;

    typedef struct packed {
        logic signed [27:0] pos_x;
        logic signed [27:0] pos_y;
        logic [2:0]         button_code;
        logic [1:0]         action_code;
        logic               dropped;
    } mrd_out_t;

    // report format currently open
    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_X10  = 4'b0010,
        P_FIVE = 4'b0100,
        P_SGR  = 4'b1000
    } mrd_proto_t;

    localparam logic [1:0] OP_CONT = 2'd0;
    localparam logic [1:0] OP_X10  = 2'd1;
    localparam logic [1:0] OP_FIVE = 2'd2;
    localparam logic [1:0] OP_SGR  = 2'd3;

    localparam logic [2:0] BTN_LEFT   = 3'd0;
    localparam logic [2:0] BTN_MIDDLE = 3'd1;
    localparam logic [2:0] BTN_RIGHT  = 3'd2;
    localparam logic [2:0] BTN_WUP    = 3'd3;
    localparam logic [2:0] BTN_WDN    = 3'd4;

    localparam logic [1:0] ACT_DOWN = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DRAG = 2'd2;

    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_UM   = 8'h4D;
    localparam logic [7:0] CH_LM   = 8'h6D;

    localparam int          ACC_W   = 27;
    localparam logic [30:0] ACC_MAX = 31'h7FF_FFFF;

    localparam logic signed [8:0] LAST_NONE = 9'sh1FF;

endpackage

>>> rtl/core/mrd_in_stage.sv
module mrd_in_stage
    import mrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    rpt_valid,
    output logic    rpt_ready,
    input  mrd_in_t rpt,
    input  logic    adv,
    output logic    item_vld,
    output mrd_in_t item
);

    logic    vld_reg;
    mrd_in_t item_reg;

    assign rpt_ready = !vld_reg || adv;
    assign item_vld  = vld_reg;
    assign item      = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (rpt_valid && rpt_ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rpt_valid && rpt_ready)
        begin
            item_reg <= rpt;
        end
    end

endmodule

>>> rtl/core/mrd_engine.sv
module mrd_engine
    import mrd_pkg::*;
#(
    parameter int SGR_FIELD_CHARS = 9
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     go,
    input  mrd_in_t  item,
    output logic     res_valid,
    output mrd_out_t res
);

    localparam int IDX_MAX = (SGR_FIELD_CHARS > 5) ? SGR_FIELD_CHARS : 5;
    localparam int IDX_W   = $clog2(IDX_MAX);

    mrd_proto_t        proto_reg, proto_next, proto_cur;
    logic [IDX_W-1:0]  idx_reg, idx_next, idx_cur;
    logic [1:0]        fsel_reg, fsel_next, fsel_cur;
    logic [ACC_W-1:0]  accb_reg, accb_next, accb_cur;
    logic [ACC_W-1:0]  accx_reg, accx_next, accx_cur;
    logic [ACC_W-1:0]  accy_reg, accy_next, accy_cur;
    logic signed [8:0] last_reg, last_next;
    logic [7:0]        held_reg [0:3];

    logic              held_we;
    logic [7:0]        c;
    logic              is_digit;
    logic [ACC_W-1:0]  acc_sel, acc_sat;
    logic [30:0]       prod;
    logic [ACC_W-1:0]  sgr_b;
    logic [2:0]        btn;
    logic [1:0]        act;
    logic signed [8:0] last_eff, now_bits, diff;

    // 5-byte coordinate: (lo-33) + 128*(hi-33), zero when bit 13 is set
    function automatic logic [27:0] split_pos(input logic [7:0] lo, input logic [7:0] hi);
        logic [16:0] lo_s;
        logic [16:0] hi_s;
        logic [16:0] p;
        lo_s = {9'b0, lo} - 17'd33;
        hi_s = {9'b0, hi} - 17'd33;
        p    = lo_s + {hi_s[9:0], 7'b0};
        if (p[13])
        begin
            p = '0;
        end
        return {{11{p[16]}}, p};
    endfunction

    assign c        = item.rx_byte;
    assign is_digit = (c inside {[CH_0:CH_9]});

    // restart on a nonzero op
    always_comb
    begin
        proto_cur = proto_reg;
        idx_cur   = idx_reg;
        fsel_cur  = fsel_reg;
        accb_cur  = accb_reg;
        accx_cur  = accx_reg;
        accy_cur  = accy_reg;
        if (item.op != OP_CONT)
        begin
            idx_cur  = '0;
            fsel_cur = '0;
            accb_cur = '0;
            accx_cur = '0;
            accy_cur = '0;
            case (item.op)
                OP_X10:  proto_cur = P_X10;
                OP_FIVE: proto_cur = P_FIVE;
                OP_SGR:  proto_cur = P_SGR;
                default: proto_cur = P_IDLE;
            endcase
        end
    end

    // decimal digit accumulate, saturating
    always_comb
    begin
        case (fsel_cur)
            2'd0:    acc_sel = accb_cur;
            2'd1:    acc_sel = accx_cur;
            default: acc_sel = accy_cur;
        endcase
        prod    = {1'b0, acc_sel, 3'b0} + {3'b0, acc_sel, 1'b0} + {27'b0, c[3:0] - 4'd0};
        acc_sat = (prod > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : prod[ACC_W-1:0];
    end

    assign last_eff = (last_reg == LAST_NONE) ? 9'sd0 : last_reg;
    assign now_bits = {1'b0, held_reg[0]} - 9'sd32;
    assign diff     = now_bits ^ last_eff;

    always_comb
    begin
        proto_next = proto_cur;
        idx_next   = idx_cur;
        fsel_next  = fsel_cur;
        accb_next  = accb_cur;
        accx_next  = accx_cur;
        accy_next  = accy_cur;
        last_next  = last_reg;
        held_we    = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        sgr_b      = accb_cur;
        btn        = BTN_LEFT;
        act        = ACT_DOWN;

        case (proto_cur)
            P_IDLE:
            begin
            end

            P_SGR:
            begin
                if (is_digit)
                begin
                    if (idx_cur >= IDX_W'(SGR_FIELD_CHARS - 1))
                    begin
                        res_valid   = 1'b1;
                        res.dropped = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_cur + IDX_W'(1);
                        case (fsel_cur)
                            2'd0:    accb_next = acc_sat;
                            2'd1:    accx_next = acc_sat;
                            default: accy_next = acc_sat;
                        endcase
                    end
                end
                else if (fsel_cur != 2'd2 && c == CH_SEMI)
                begin
                    fsel_next = fsel_cur + 2'd1;
                    idx_next  = '0;
                end
                else if (fsel_cur == 2'd2 && (c == CH_UM || c == CH_LM))
                begin
                    if (c == CH_LM)
                    begin
                        act = ACT_UP;
                    end
                    else if (sgr_b[5])
                    begin
                        act      = ACT_DRAG;
                        sgr_b[5] = 1'b0;
                    end
                    case (sgr_b)
                        27'd1:    btn = BTN_MIDDLE;
                        27'd2:    btn = BTN_RIGHT;
                        27'd3:    btn = last_reg[8] ? BTN_LEFT : last_reg[2:0];
                        27'h40:   btn = BTN_WUP;
                        27'h41:   btn = BTN_WDN;
                        default:  btn = BTN_LEFT;
                    endcase
                    last_next       = (act == ACT_DOWN) ? {6'b0, btn} : LAST_NONE;
                    res_valid       = 1'b1;
                    res.pos_x       = {1'b0, accx_cur} - 28'd1;
                    res.pos_y       = {1'b0, accy_cur} - 28'd1;
                    res.button_code = btn;
                    res.action_code = act;
                end
                else
                begin
                    res_valid   = 1'b1;
                    res.dropped = 1'b1;
                end
            end

            P_X10:
            begin
                if (idx_cur >= IDX_W'(2))
                begin
                    btn = held_reg[0][2:0];
                    if (btn == 3'd3 && last_reg != LAST_NONE)
                    begin
                        btn = last_reg[2:0];
                        act = ACT_UP;
                    end
                    if (held_reg[0][6:5] == 2'b11)
                    begin
                        btn = held_reg[0][0] ? BTN_WDN : BTN_WUP;
                        act = ACT_DOWN;
                    end
                    last_next       = (act == ACT_DOWN) ? {6'b0, btn} : LAST_NONE;
                    res_valid       = 1'b1;
                    res.pos_x       = {20'b0, held_reg[1]} - 28'd33;
                    res.pos_y       = {20'b0, c} - 28'd33;
                    res.button_code = btn;
                    res.action_code = act;
                end
                else
                begin
                    held_we  = 1'b1;
                    idx_next = idx_cur + IDX_W'(1);
                end
            end

            P_FIVE:
            begin
                if (idx_cur >= IDX_W'(4))
                begin
                    case (diff)
                        9'sd1:
                        begin
                            btn = BTN_LEFT;
                            act = last_eff[0] ? ACT_UP : ACT_DOWN;
                        end
                        9'sd2:
                        begin
                            btn = BTN_MIDDLE;
                            act = last_eff[1] ? ACT_UP : ACT_DOWN;
                        end
                        9'sd4:
                        begin
                            btn = BTN_RIGHT;
                            act = last_eff[2] ? ACT_UP : ACT_DOWN;
                        end
                        9'sd0:
                        begin
                            btn = BTN_LEFT;
                            act = ACT_DRAG;
                        end
                        default:
                        begin
                            btn = BTN_LEFT;
                            act = ACT_DOWN;
                        end
                    endcase
                    last_next       = now_bits;
                    res_valid       = 1'b1;
                    res.pos_x       = split_pos(held_reg[1], held_reg[2]);
                    res.pos_y       = split_pos(held_reg[3], c);
                    res.button_code = btn;
                    res.action_code = act;
                end
                else
                begin
                    held_we  = 1'b1;
                    idx_next = idx_cur + IDX_W'(1);
                end
            end

            default:
            begin
            end
        endcase

        // any result closes the report
        if (res_valid)
        begin
            proto_next = P_IDLE;
            idx_next   = '0;
            fsel_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proto_reg <= P_IDLE;
            idx_reg   <= '0;
            fsel_reg  <= '0;
            accb_reg  <= '0;
            accx_reg  <= '0;
            accy_reg  <= '0;
            last_reg  <= LAST_NONE;
        end
        else if (go)
        begin
            proto_reg <= proto_next;
            idx_reg   <= idx_next;
            fsel_reg  <= fsel_next;
            accb_reg  <= accb_next;
            accx_reg  <= accx_next;
            accy_reg  <= accy_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && held_we)
        begin
            held_reg[idx_cur[1:0]] <= c;
        end
    end

endmodule

>>> rtl/core/terminal_mouse_report_decoder_core.sv
// Mouse report decoder: one report byte per item, one event or drop status per finished report.
// Path: the accepting edge loads the input register, then the event register raises event valid.
// Throughput: 1 item per cycle; all per-byte decode is one combinational pass between them.
// Reset: asynchronous, active low; block idle, no report open, no remembered button.
// Both stages hold while an event waits with evt_ready low; rpt_ready drops once the input register is full.
module terminal_mouse_report_decoder_core
    import mrd_pkg::*;
#(
    parameter int SGR_FIELD_CHARS = 9
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rpt_valid,
    output logic     rpt_ready,
    input  mrd_in_t  rpt,
    output logic     evt_valid,
    input  logic     evt_ready,
    output mrd_out_t evt
);

    logic     adv;
    logic     item_vld;
    mrd_in_t  item;
    logic     res_valid;
    mrd_out_t res;
    logic     evt_vld_reg;
    mrd_out_t evt_reg;

    assign adv       = item_vld && (!evt_vld_reg || evt_ready);
    assign evt_valid = evt_vld_reg;
    assign evt       = evt_reg;

    mrd_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt),
        .adv       (adv),
        .item_vld  (item_vld),
        .item      (item)
    );

    mrd_engine #(
        .SGR_FIELD_CHARS (SGR_FIELD_CHARS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (adv),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_vld_reg <= 1'b0;
        end
        else if (adv && res_valid)
        begin
            evt_vld_reg <= 1'b1;
        end
        else if (evt_ready)
        begin
            evt_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && res_valid)
        begin
            evt_reg <= res;
        end
    end

endmodule

>>> verif/mouse_event_checker.sv
module mouse_event_checker
    import mrd_pkg::*;
#(
    parameter int SGR_FIELD_CHARS = 9
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     rpt_valid,
    input  logic     rpt_ready,
    input  mrd_in_t  rpt,
    input  logic     evt_valid,
    input  logic     evt_ready,
    input  mrd_out_t evt,
    output int       fail_count,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]  X10_RELEASE = 3'd3;
    localparam logic [26:0] SB_MIDDLE   = 27'd1;
    localparam logic [26:0] SB_RIGHT    = 27'd2;
    localparam logic [26:0] SB_RELEASE  = 27'd3;
    localparam logic [26:0] SB_DRAG     = 27'h20;
    localparam logic [26:0] SB_WHEEL_UP = 27'h40;
    localparam logic [26:0] SB_WHEEL_DN = 27'h41;

    // decoder state as seen from outside
    mrd_proto_t  proto;
    int unsigned idx;
    logic [7:0]  held [4];
    int unsigned fsel;
    logic [26:0] acc_btn, acc_x, acc_y;
    int          last_btn;

    mrd_out_t    expected_events [$];

    function automatic void close_report();
        proto = P_IDLE;
        idx   = 0;
        fsel  = 0;
    endfunction

    function automatic logic [27:0] five_coord(input logic [7:0] lo, input logic [7:0] hi);
        int p;
        p = (int'(lo) - 33) + (int'(hi) - 33) * 128;
        if ((p & 'h2000) != 0)
            p = 0;
        return 28'(p);
    endfunction

    function automatic bit predict_event(input mrd_in_t it, output mrd_out_t ev);
        logic [7:0]  c;
        logic [26:0] acc, sb;
        logic [2:0]  btn;
        logic [1:0]  act;
        longint      v;
        int          cur_bits, old_bits;
        c   = it.rx_byte;
        ev  = '0;
        btn = BTN_LEFT;
        act = ACT_DOWN;
        if (it.op != OP_CONT)
        begin
            case (it.op)
                OP_X10:  proto = P_X10;
                OP_FIVE: proto = P_FIVE;
                default: proto = P_SGR;
            endcase
            idx     = 0;
            fsel    = 0;
            acc_btn = '0;
            acc_x   = '0;
            acc_y   = '0;
        end
        if (proto == P_IDLE)
            return 1'b0;

        if (proto == P_SGR)
        begin
            if (c >= CH_0 && c <= CH_9)
            begin
                if (idx + 1 >= SGR_FIELD_CHARS)
                begin
                    ev.dropped = 1'b1;
                    close_report();
                    return 1'b1;
                end
                acc = (fsel == 0) ? acc_btn : (fsel == 1) ? acc_x : acc_y;
                v   = longint'(acc) * 10 + longint'(c - CH_0);
                acc = (v > longint'(ACC_MAX)) ? 27'(ACC_MAX) : 27'(v);
                case (fsel)
                    0:       acc_btn = acc;
                    1:       acc_x   = acc;
                    default: acc_y   = acc;
                endcase
                idx++;
                return 1'b0;
            end
            if (fsel < 2 && c == CH_SEMI)
            begin
                fsel++;
                idx = 0;
                return 1'b0;
            end
            if (fsel == 2 && (c == CH_UM || c == CH_LM))
            begin
                sb = acc_btn;
                if (c == CH_LM)
                    act = ACT_UP;
                else if ((sb & SB_DRAG) != 0)
                begin
                    act = ACT_DRAG;
                    sb  = sb & ~SB_DRAG;
                end
                if (sb == SB_MIDDLE)
                    btn = BTN_MIDDLE;
                else if (sb == SB_RIGHT)
                    btn = BTN_RIGHT;
                else if (sb == SB_RELEASE && last_btn >= 0)
                    btn = 3'(last_btn);
                else if (sb == SB_WHEEL_UP)
                    btn = BTN_WUP;
                else if (sb == SB_WHEEL_DN)
                    btn = BTN_WDN;
                last_btn = (act == ACT_DOWN) ? int'(btn) : -1;
                ev = '{pos_x: {1'b0, acc_x} - 28'd1, pos_y: {1'b0, acc_y} - 28'd1,
                       button_code: btn, action_code: act, dropped: 1'b0};
                close_report();
                return 1'b1;
            end
            ev.dropped = 1'b1;
            close_report();
            return 1'b1;
        end

        if (proto == P_X10 && idx >= 2)
        begin
            held[2] = c;
            btn = held[0][2:0];
            if (btn == X10_RELEASE && last_btn != -1)
            begin
                btn = 3'(last_btn);
                act = ACT_UP;
            end
            // both 0x60 bits set: wheel, direction in bit 0
            if (held[0][6:5] == 2'b11)
            begin
                btn = held[0][0] ? BTN_WDN : BTN_WUP;
                act = ACT_DOWN;
            end
            last_btn = (act == ACT_DOWN) ? int'(btn) : -1;
            ev = '{pos_x: {20'd0, held[1]} - 28'd33, pos_y: {20'd0, c} - 28'd33,
                   button_code: btn, action_code: act, dropped: 1'b0};
            close_report();
            return 1'b1;
        end

        if (proto == P_FIVE && idx >= 4)
        begin
            cur_bits = int'(held[0]) - 32;
            if (last_btn == -1)
                last_btn = 0;
            old_bits = last_btn;
            // exactly one of the three low bits changed, or nothing did; any other change reads as a left press
            case (cur_bits ^ old_bits)
                1:
                begin
                    btn = BTN_LEFT;
                    act = (old_bits & 1) ? ACT_UP : ACT_DOWN;
                end
                2:
                begin
                    btn = BTN_MIDDLE;
                    act = (old_bits & 2) ? ACT_UP : ACT_DOWN;
                end
                4:
                begin
                    btn = BTN_RIGHT;
                    act = (old_bits & 4) ? ACT_UP : ACT_DOWN;
                end
                0:       act = ACT_DRAG;
                default: act = ACT_DOWN;
            endcase
            last_btn = cur_bits;
            ev = '{pos_x: five_coord(held[1], held[2]), pos_y: five_coord(held[3], c),
                   button_code: btn, action_code: act, dropped: 1'b0};
            close_report();
            return 1'b1;
        end

        held[idx % 4] = c;
        idx++;
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mrd_out_t ev;
        mrd_out_t want;
        if (!rst_n)
        begin
            proto    = P_IDLE;
            idx      = 0;
            fsel     = 0;
            acc_btn  = '0;
            acc_x    = '0;
            acc_y    = '0;
            last_btn = -1;
            expected_events.delete();
        end
        else
        begin
            // compare first: an item accepted at this edge cannot be answered yet
            if (evt_valid && evt_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event with none expected: x %0d y %0d btn %0d act %0d drop %0d",
                           evt.pos_x, evt.pos_y, evt.button_code, evt.action_code,
                           evt.dropped);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("pos_x", longint'(want.pos_x), longint'(evt.pos_x));
                    check_field("pos_y", longint'(want.pos_y), longint'(evt.pos_y));
                    check_field("button_code", longint'(want.button_code),
                                longint'(evt.button_code));
                    check_field("action_code", longint'(want.action_code),
                                longint'(evt.action_code));
                    check_field("dropped", longint'(want.dropped), longint'(evt.dropped));
                end
            end
            if (rpt_valid && rpt_ready)
            begin
                if (predict_event(rpt, ev))
                    expected_events.push_back(ev);
            end
        end
        pending = expected_events.size();
    end

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrd_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     rpt_valid;
    logic     rpt_ready;
    mrd_in_t  rpt;
    logic     evt_valid;
    logic     evt_ready = 1'b0;
    mrd_out_t evt;

    int       fail_count;
    int       pending;
    int       send_idle;
    int       recv_idle;
    int       report_bytes;

    terminal_mouse_report_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rpt_valid (rpt_valid),
        .rpt_ready (rpt_ready),
        .rpt       (rpt),
        .evt_valid (evt_valid),
        .evt_ready (evt_ready),
        .evt       (evt)
    );

    mouse_event_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .rpt_valid  (rpt_valid),
        .rpt_ready  (rpt_ready),
        .rpt        (rpt),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_ready <= 1'b0;
        else
            evt_ready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_byte(input logic [7:0] b, input logic [1:0] op);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle)
            gap++;
        if (gap > 0)
        begin
            rpt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rpt_valid <= 1'b1;
        rpt       <= '{rx_byte: b, op: op};
        do
            @(posedge clk);
        while (!rpt_ready);
    endtask

    task automatic send_report(input logic [1:0] op, input logic [7:0] b [5], input int n);
        for (int i = 0; i < n; i++)
            send_byte(b[i], (i == 0) ? op : OP_CONT);
        report_bytes += n;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], (i == 0) ? OP_SGR : OP_CONT);
        report_bytes += s.len();
    endtask

    // empty, small, long, or long with a leading zero (may overflow the field)
    function automatic string sgr_field();
        int k;
        k = $urandom_range(15);
        if (k == 0)
            return "";
        if (k == 1)
            return $sformatf("0%0d", $urandom_range(99999999));
        if (k < 4)
            return $sformatf("%0d", $urandom_range(99999999));
        return $sformatf("%0d", $urandom_range(250));
    endfunction

    task automatic random_traffic(input int n_items);
        int          first;
        int          r;
        int          btn_val;
        int          picks [6];
        logic [7:0]  b [5];
        string       s;
        first = report_bytes;
        picks = '{0, 1, 2, 3, 64, 65};
        while (report_bytes - first < n_items)
        begin
            r = $urandom_range(19);
            for (int i = 0; i < 5; i++)
                b[i] = 8'($urandom_range(255));
            if (r < 6)
            begin
                if ($urandom_range(1))
                    b[0] = 8'(32 + picks[$urandom_range(5)]);
                send_report(OP_X10, b, 3);
            end
            else if (r < 10)
            begin
                if ($urandom_range(3) != 0)
                begin
                    b[0] = 8'(32 + $urandom_range(7));
                    b[1] = 8'($urandom_range(33, 160));
                    b[2] = 8'($urandom_range(33, 40));
                    b[3] = 8'($urandom_range(33, 160));
                    b[4] = 8'($urandom_range(33, 40));
                end
                send_report(OP_FIVE, b, 5);
            end
            else if (r < 18)
            begin
                if ($urandom_range(9) < 8)
                    btn_val = picks[$urandom_range(5)] + ($urandom_range(1) ? 32 : 0);
                else
                    btn_val = $urandom_range(255);
                s = $sformatf("%0d;%s;%s%s", btn_val, sgr_field(), sgr_field(),
                              $urandom_range(1) ? "M" : "m");
                // broken report: one character replaced
                if (r == 17)
                    s.putc($urandom_range(s.len() - 1), 8'($urandom_range(1, 255)));
                send_text(s);
            end
            else if (r == 18)
            begin
                // short report, mostly unfinished and then abandoned by whatever starts next
                send_report(2'($urandom_range(1, 3)), b, $urandom_range(1, 3));
            end
            else
            begin
                repeat ($urandom_range(1, 2))
                    send_byte(8'($urandom_range(255)), OP_CONT);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        rpt_valid    = 1'b0;
        rpt          = '0;
        report_bytes = 0;
        send_idle    = 22;
        recv_idle    = 85;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'hFF, OP_CONT);                                  // nothing open
        send_report(OP_X10, '{8'h23, 8'hFF, 8'h00, 8'h00, 8'h00}, 3); // release, none held
        send_report(OP_X10, '{8'h23, 8'h21, 8'h21, 8'h00, 8'h00}, 3); // release of held
        send_report(OP_X10, '{8'h61, 8'h80, 8'h80, 8'h00, 8'h00}, 3); // wheel down
        send_report(OP_FIVE, '{8'h21, 8'h21, 8'h21, 8'hFF, 8'hFF}, 5); // row wraps to 0
        send_text("x");                                             // bad character
        send_text("123456789");                                     // field too long
        send_text("35;;M");                                         // drag, empty fields

        random_traffic(200);
        send_idle = 85;
        recv_idle = 22;
        random_traffic(210);
        send_idle = 0;
        recv_idle = 0;
        random_traffic(210);

        rpt_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
